// File: src/egw_pkg.sv
`timescale 1ns / 1ps
// Shared types, operation codes and constants for the Exp-Golomb bitstream writer.
// No dependencies; every other file in src refers to this package by scoped names.
package egw_pkg;

  // Field widths fixed by the item format
  localparam int WORD_W       = 64;
  localparam int CNT_W        = 7;
  localparam int ZERO_W       = 6;
  localparam int MAX_RAW_BITS = 64;

  // Input operation codes
  localparam logic [1:0] OP_RAW   = 2'd0;
  localparam logic [1:0] OP_UE    = 2'd1;
  localparam logic [1:0] OP_SE    = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  // Command kinds passed from the front end to the bit packer
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_FLUSH = 2'd1;
  localparam logic [1:0] CMD_ERROR = 2'd2;

  // Emulation prevention byte
  localparam logic [7:0] EPB_BYTE = 8'h03;

  typedef struct packed {
    logic [1:0]              operation;
    logic [WORD_W-1:0]       value;
    logic signed [WORD_W-1:0] signed_value;
    logic [CNT_W-1:0]        bit_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } out_item_t;

  // Bit string: 'zeros' zero bits, then the top 'nbits' bits of 'word'
  typedef struct packed {
    logic [1:0]        kind;
    logic [ZERO_W-1:0] zeros;
    logic [CNT_W-1:0]  nbits;
    logic [WORD_W-1:0] word;
  } cmd_t;

  // Handshake between the front end and the command queue
  typedef struct packed {
    logic valid;
    logic ready;
  } cmd_hs_t;

endpackage

// File: src/exp_golomb_bitstream_writer.sv
`timescale 1ns / 1ps
// Top level of the Exp-Golomb bitstream writer: configuration register and wiring.
// Depends on egw_pkg, egw_front, egw_cmdq and egw_back.

// Packs raw fields, ue(v) and se(v) codes MSB first into bytes and sends each finished
// byte as one result beat, with last set on the final beat of an item; a flush pads the
// open byte with zeros. With emulation prevention on, 0x03 goes out before any byte of
// 0..3 that follows two zero bytes. A ue value of all ones, or a raw count above 64,
// gives one beat with error set and writes nothing. An item passes a two-stage front
// end (code add, then leading-zero search with the alignment shift on its output) and
// a two-entry command queue; its first byte passes stage A, stage B, the queue, the
// packer's current command register and the result buffer. The bit packer then writes
// one byte-bounded piece of the code per cycle while the result buffer has room: the
// zero prefix and the payload are separate pieces, and each prevention byte takes a
// step of its own. Results wait in a two-entry buffer, so pop can stall without
// blocking input until the queues fill.
module exp_golomb_bitstream_writer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_data_i,
  input  logic               push,
  output logic               full,
  input  egw_pkg::in_item_t  item_i,
  output logic               empty,
  input  logic               pop,
  output egw_pkg::out_item_t result_o
);

  logic             epo_q;
  egw_pkg::cmd_t    f_cmd, q_cmd;
  egw_pkg::cmd_hs_t f_hs;
  logic             q_full, q_empty, q_pop;

  // Emulation prevention enable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epo_q <= 1'b0;
    end else if (cfg_we_i) begin
      epo_q <= cfg_data_i;
    end
  end

  egw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .cmd_o       (f_cmd),
    .cmd_hs_o    (f_hs),
    .cmd_ready_i (!q_full)
  );

  egw_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_hs.valid),
    .data_i  (f_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_cmd)
  );

  egw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .epo_i       (epo_q),
    .cmd_i       (q_cmd),
    .cmd_empty_i (q_empty),
    .cmd_pop_o   (q_pop),
    .res_empty_o (empty),
    .res_pop_i   (pop),
    .res_o       (result_o)
  );

  a_front_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_hs.valid && !q_full |-> f_hs.ready)
    else $error("front end stalled while queue had room");

endmodule

// File: src/egw_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, builds the code word and classifies it into a command.
// Depends on egw_pkg.
module egw_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  egw_pkg::in_item_t item_i,
  output egw_pkg::cmd_t     cmd_o,
  output egw_pkg::cmd_hs_t  cmd_hs_o,
  input  logic              cmd_ready_i
);

  localparam logic [1:0] FK_RAW   = 2'd0;
  localparam logic [1:0] FK_UE    = 2'd1;
  localparam logic [1:0] FK_FLUSH = 2'd2;
  localparam logic [1:0] FK_ERR   = 2'd3;

  function automatic logic [2:0] clz8(input logic [7:0] x);
    logic [2:0] r;
    r = 3'd7;
    for (int i = 0; i < 8; i++) begin
      if (x[i]) r = 3'(7 - i);
    end
    return r;
  endfunction

  // Stage A: code word
  logic                        va_q, va_d;
  logic [1:0]                  kinda_q, kinda_d;
  logic [egw_pkg::WORD_W-1:0]  worda_q, worda_d;
  logic [egw_pkg::CNT_W-1:0]   cnta_q, cnta_d;
  // Stage B: per-byte leading-zero information
  logic                        vb_q, vb_d;
  logic [1:0]                  kindb_q;
  logic [egw_pkg::WORD_W-1:0]  wordb_q;
  logic [egw_pkg::CNT_W-1:0]   cntb_q;
  logic [7:0]                  nzb_q;
  logic [2:0]                  clzb_q [8];

  logic                        a_free, b_free, accept;
  logic [egw_pkg::WORD_W-1:0]  s_dbl, add_a, add_b, raw_word;
  logic                        s_neg, s_zero;
  logic [2:0]                  sel;
  logic [egw_pkg::ZERO_W-1:0]  lz;

  // Pipeline flow
  assign b_free = !vb_q || cmd_ready_i;
  assign a_free = !va_q || b_free;
  assign full   = !a_free;
  assign accept = push && a_free;

  // Build the code number plus one with one adder; left-align raw fields
  always_comb begin
    s_dbl    = item_i.signed_value << 1;
    s_neg    = item_i.signed_value[egw_pkg::WORD_W-1];
    s_zero   = (item_i.signed_value == '0);
    raw_word = item_i.value << (7'(egw_pkg::WORD_W) - item_i.bit_count);
    add_a    = '0;
    add_b    = '0;
    kinda_d  = FK_FLUSH;
    case (item_i.operation)
      egw_pkg::OP_RAW: begin
        kinda_d = (item_i.bit_count > 7'(egw_pkg::MAX_RAW_BITS)) ? FK_ERR : FK_RAW;
      end
      egw_pkg::OP_UE: begin
        kinda_d = (item_i.value == '1) ? FK_ERR : FK_UE;
        add_a   = item_i.value;
        add_b   = 64'd1;
      end
      egw_pkg::OP_SE: begin
        kinda_d = FK_UE;
        if (s_neg) begin
          add_a = ~s_dbl;
          add_b = 64'd2;
        end else if (s_zero) begin
          add_b = 64'd1;
        end else begin
          add_a = s_dbl;
        end
      end
      default: kinda_d = FK_FLUSH;
    endcase
    worda_d = (item_i.operation == egw_pkg::OP_RAW) ? raw_word : add_a + add_b;
    cnta_d  = item_i.bit_count;
    va_d    = a_free ? accept : va_q;
    vb_d    = b_free ? va_q : vb_q;
  end

  // Find the leading one and emit the command
  always_comb begin
    sel = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (nzb_q[j]) sel = 3'(j);
    end
    lz    = {sel, clzb_q[sel]};
    cmd_o = '0;
    case (kindb_q)
      FK_RAW: begin
        cmd_o.kind  = egw_pkg::CMD_WRITE;
        cmd_o.nbits = cntb_q;
        cmd_o.word  = wordb_q;
      end
      FK_UE: begin
        cmd_o.kind  = egw_pkg::CMD_WRITE;
        cmd_o.zeros = ~lz;
        cmd_o.nbits = 7'(egw_pkg::WORD_W) - 7'(lz);
        cmd_o.word  = wordb_q << lz;
      end
      FK_FLUSH: cmd_o.kind = egw_pkg::CMD_FLUSH;
      default:  cmd_o.kind = egw_pkg::CMD_ERROR;
    endcase
    cmd_hs_o.valid = vb_q;
    cmd_hs_o.ready = b_free;
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= va_d;
      vb_q <= vb_d;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kinda_q <= kinda_d;
      worda_q <= worda_d;
      cnta_q  <= cnta_d;
    end
    if (b_free && va_q) begin
      kindb_q <= kinda_q;
      wordb_q <= worda_q;
      cntb_q  <= cnta_q;
      for (int j = 0; j < 8; j++) begin
        nzb_q[j]  <= |worda_q[egw_pkg::WORD_W-1-8*j -: 8];
        clzb_q[j] <= clz8(worda_q[egw_pkg::WORD_W-1-8*j -: 8]);
      end
    end
  end

endmodule

// File: src/egw_cmdq.sv
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the bit packer.
// Depends on egw_pkg.
module egw_cmdq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  egw_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output egw_pkg::cmd_t data_o
);

  egw_pkg::cmd_t mem_q [2];
  logic          wr_q, wr_d, rd_q, rd_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  // Advance pointers and occupancy
  always_comb begin
    do_push = push_i && !full_o;
    do_pop  = pop_i && !empty_o;
    wr_d    = do_push ? !wr_q : wr_q;
    rd_d    = do_pop ? !rd_q : rd_q;
    cnt_d   = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

// File: src/egw_back.sv
`timescale 1ns / 1ps
// Bit packer: writes commands into bytes, inserts prevention bytes, buffers results.
// Depends on egw_pkg.
module egw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               epo_i,
  input  egw_pkg::cmd_t      cmd_i,
  input  logic               cmd_empty_i,
  output logic               cmd_pop_o,
  output logic               res_empty_o,
  input  logic               res_pop_i,
  output egw_pkg::out_item_t res_o
);

  egw_pkg::cmd_t      cur_q, cur_d;
  logic               cur_v_q, cur_v_d;
  logic [7:0]         part_q, part_d;
  logic [2:0]         bp_q, bp_d;
  logic [1:0]         zrun_q, zrun_d;

  egw_pkg::out_item_t obuf_q [2];
  logic               owr_q, ord_q;
  logic [1:0]         ocnt_q, ocnt_d;

  logic               zero_phase, completes, insert, space, step_done, push, ins_push, opop;
  logic [3:0]         avail, k;
  logic [7:0]         top, chunk, merged, emit_b;
  logic [6:0]         rem_after;
  logic [1:0]         zrun_next;
  egw_pkg::out_item_t res_new;

  assign res_empty_o = (ocnt_q == 2'd0);
  assign res_o       = obuf_q[ord_q];
  assign opop        = res_pop_i && !res_empty_o;

  // Take up to the rest of the open byte from the current command each cycle
  always_comb begin
    cur_d     = cur_q;
    cur_v_d   = cur_v_q;
    part_d    = part_q;
    bp_d      = bp_q;
    zrun_d    = zrun_q;
    push      = 1'b0;
    ins_push  = 1'b0;
    res_new   = '0;
    step_done = 1'b0;

    avail      = {1'b0, bp_q} + 4'd1;
    zero_phase = (cur_q.zeros != '0);
    if (zero_phase) begin
      k = (7'(cur_q.zeros) < 7'(avail)) ? cur_q.zeros[3:0] : avail;
    end else begin
      k = (cur_q.nbits < 7'(avail)) ? cur_q.nbits[3:0] : avail;
    end
    top       = zero_phase ? 8'h00 : cur_q.word[egw_pkg::WORD_W-1 -: 8];
    chunk     = top & (8'hFF << (4'd8 - k));
    merged    = part_q | (chunk >> (3'd7 - bp_q));
    completes = (k == avail);
    rem_after = 7'(cur_q.zeros) + cur_q.nbits - 7'(k);
    emit_b    = (cur_q.kind == egw_pkg::CMD_FLUSH) ? part_q : merged;
    insert    = epo_i && (zrun_q == 2'd2) && (emit_b <= 8'd3);
    space     = (ocnt_q != 2'd2);
    if (emit_b == 8'd0) begin
      zrun_next = (zrun_q == 2'd3) ? 2'd3 : zrun_q + 2'd1;
    end else begin
      zrun_next = 2'd0;
    end

    if (cur_v_q) begin
      case (cur_q.kind)
        egw_pkg::CMD_WRITE: begin
          if (cur_q.zeros == '0 && cur_q.nbits == '0) begin
            step_done = 1'b1;
          end else if (completes && !space) begin
            step_done = 1'b0;
          end else if (completes && insert) begin
            // Send the prevention byte, then retry the same step
            push             = 1'b1;
            ins_push         = 1'b1;
            res_new.out_byte = egw_pkg::EPB_BYTE;
            zrun_d           = 2'd0;
          end else begin
            if (zero_phase) begin
              cur_d.zeros = cur_q.zeros - 6'(k);
            end else begin
              cur_d.nbits = cur_q.nbits - 7'(k);
              cur_d.word  = cur_q.word << k;
            end
            if (completes) begin
              push             = 1'b1;
              res_new.out_byte = merged;
              res_new.last     = (rem_after < 7'd8);
              zrun_d           = zrun_next;
              part_d           = 8'h00;
              bp_d             = 3'd7;
            end else begin
              part_d = merged;
              bp_d   = bp_q - 3'(k);
            end
            step_done = (rem_after == 7'd0);
          end
        end
        egw_pkg::CMD_FLUSH: begin
          if (bp_q == 3'd7) begin
            step_done = 1'b1;
          end else if (!space) begin
            step_done = 1'b0;
          end else if (insert) begin
            push             = 1'b1;
            ins_push         = 1'b1;
            res_new.out_byte = egw_pkg::EPB_BYTE;
            zrun_d           = 2'd0;
          end else begin
            push             = 1'b1;
            res_new.out_byte = part_q;
            res_new.last     = 1'b1;
            zrun_d           = zrun_next;
            part_d           = 8'h00;
            bp_d             = 3'd7;
            step_done        = 1'b1;
          end
        end
        egw_pkg::CMD_ERROR: begin
          if (space) begin
            push          = 1'b1;
            res_new.last  = 1'b1;
            res_new.error = 1'b1;
            step_done     = 1'b1;
          end
        end
        default: step_done = 1'b1;
      endcase
    end

    // Drop the finished command, load the next one
    cmd_pop_o = (!cur_v_q || step_done) && !cmd_empty_i;
    if (cur_v_q && step_done) cur_v_d = 1'b0;
    if (cmd_pop_o) begin
      cur_v_d = 1'b1;
      cur_d   = cmd_i;
    end

    ocnt_d = ocnt_q + 2'(push) - 2'(opop);
  end

  // Packer state and result buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      part_q  <= 8'h00;
      bp_q    <= 3'd7;
      zrun_q  <= 2'd0;
      owr_q   <= 1'b0;
      ord_q   <= 1'b0;
      ocnt_q  <= 2'd0;
    end else begin
      cur_v_q <= cur_v_d;
      part_q  <= part_d;
      bp_q    <= bp_d;
      zrun_q  <= zrun_d;
      ocnt_q  <= ocnt_d;
      if (push) owr_q <= !owr_q;
      if (opop) ord_q <= !ord_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (push) obuf_q[owr_q] <= res_new;
  end

  a_ocnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= 2'd2)
    else $error("result buffer overfilled");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && res_new.error |-> res_new.last && res_new.out_byte == 8'h00)
    else $error("error beat not marked last");

  a_low_bits_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (part_q & (8'hFF >> (3'd7 - bp_q))) == 8'h00)
    else $error("open byte has bits at or below the write position");

  a_ins_resets_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_push |=> zrun_q == 2'd0 && !$past(res_new.last))
    else $error("zero run not cleared after prevention byte");

endmodule
